// ===== hdl/tsp_pkg.sv =====
// Shared types and constants for the tube surface point core.
`default_nettype none
package tsp_pkg;

	// One sine evaluation travelling through the Horner chain.
	typedef struct packed {
		logic [16:0]        u;   // quadrant position, Q16, 0..65536
		logic [30:0]        z;   // u*u/4, Q30
		logic signed [32:0] r;   // Horner accumulator, Q30
	} sine_lane_t;

	localparam int SINE_LANES   = 2;
	localparam int HORNER_CELLS = 4;

	localparam logic signed [32:0] SIN_C1 = 33'sd1686629713;
	localparam logic signed [32:0] SIN_C3 = -33'sd693598668;
	localparam logic signed [32:0] SIN_C5 = 33'sd85569306;
	localparam logic signed [32:0] SIN_C7 = -33'sd5026995;
	localparam logic signed [32:0] SIN_C9 = 33'sd172272;

	localparam logic [14:0] SIN_ONE = 15'd16384;

	// Coefficient added by Horner cell idx (highest order first).
	function automatic logic signed [32:0] horner_coef(input int idx);
		logic signed [32:0] c;
		case (idx)
			0:       c = SIN_C7;
			1:       c = SIN_C5;
			2:       c = SIN_C3;
			default: c = SIN_C1;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/tsp_sine_cell.sv =====
// One Horner step of the quarter-sine polynomial for both sine lanes.
`default_nettype none
module tsp_sine_cell import tsp_pkg::*; #(
	parameter logic signed [32:0] COEF   = 33'sd0,
	parameter int                 SIDE_W = 8
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output      logic                    in_ready,
	input  wire sine_lane_t [SINE_LANES-1:0] in_lane,
	input  wire logic [SIDE_W-1:0]       in_side,
	output      logic                    out_valid,
	input  wire logic                    out_ready,
	output      sine_lane_t [SINE_LANES-1:0] out_lane,
	output      logic [SIDE_W-1:0]       out_side
);

	logic                        valid_q;
	sine_lane_t [SINE_LANES-1:0] lane_q;
	logic [SIDE_W-1:0]           side_q;
	sine_lane_t [SINE_LANES-1:0] lane_d;
	logic signed [64:0]          prod [SINE_LANES];

	assign in_ready = !valid_q || out_ready;

	always_comb begin
		for (int i = 0; i < SINE_LANES; i++) begin
			prod[i]        = in_lane[i].r * $signed({1'b0, in_lane[i].z});
			lane_d[i].u    = in_lane[i].u;
			lane_d[i].z    = in_lane[i].z;
			lane_d[i].r    = COEF + 33'(prod[i] >>> 30);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			lane_q <= lane_d;
			side_q <= in_side;
		end
	end

	assign out_valid = valid_q;
	assign out_lane  = lane_q;
	assign out_side  = side_q;

endmodule
`default_nettype wire

// ===== hdl/tsp_axis_rotate.sv =====
// Sine finish, Rodrigues rotation, radius scaling and saturated offset stages.
`default_nettype none
module tsp_axis_rotate import tsp_pkg::*; #(
	parameter int COORD_BITS = 24,
	parameter int SIDE_W     = 262 + 3 * 24
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output      logic                    in_ready,
	input  wire sine_lane_t [SINE_LANES-1:0] in_lane,
	input  wire logic [SIDE_W-1:0]       in_side,
	output      logic                    out_valid,
	input  wire logic                    out_ready,
	output      logic [15:0]             tag,
	output      logic [3*COORD_BITS-1:0] vertex
);

	localparam int NSTG  = 6;
	localparam int O_TAG = 2;
	localparam int O_K   = 18;
	localparam int O_V   = 66;
	localparam int O_CEN = 114;
	localparam int O_RAD = O_CEN + 3 * COORD_BITS;
	localparam int O_CR  = O_RAD + 16;
	localparam int O_KV  = O_CR + 99;
	localparam int CW    = 3 * COORD_BITS;
	localparam int SUM_W = ((COORD_BITS > 25) ? COORD_BITS : 25) + 1;
	localparam logic signed [SUM_W-1:0] MAXV = SUM_W'((64'sd1 <<< (COORD_BITS - 1)) - 1);
	localparam logic signed [SUM_W-1:0] MINV = SUM_W'(-(64'sd1 <<< (COORD_BITS - 1)));

	logic [NSTG-1:0] vld_q;
	logic [NSTG:0]   en;

	always_comb begin
		en[NSTG] = out_ready;
		for (int i = NSTG - 1; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end
	assign in_ready  = en[0];
	assign out_valid = vld_q[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < NSTG; i++) begin
				if (en[i]) begin
					vld_q[i] <= (i == 0) ? in_valid : vld_q[i-1];
				end
			end
		end
	end

	// s6: finish both sines
	logic signed [50:0] sp   [SINE_LANES];
	logic signed [50:0] st   [SINE_LANES];
	logic signed [50:0] sr   [SINE_LANES];
	logic [14:0]        sv   [SINE_LANES];
	logic [14:0]        sx_s6, cx_s6;
	logic [SIDE_W-1:0]  side_s6;

	always_comb begin
		for (int i = 0; i < SINE_LANES; i++) begin
			sp[i] = in_lane[i].r * $signed({1'b0, in_lane[i].u});
			st[i] = sp[i] >>> 16;
			sr[i] = (st[i] + 51'sd32768) >>> 16;
			if (sr[i] < 0) begin
				sv[i] = '0;
			end else if (sr[i] > 51'sd16384) begin
				sv[i] = SIN_ONE;
			end else begin
				sv[i] = sr[i][14:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0] && in_valid) begin
			sx_s6   <= sv[0];
			cx_s6   <= sv[1];
			side_s6 <= in_side;
		end
	end

	// s7: quadrant select and first products
	logic [1:0]         q6;
	logic signed [15:0] sn, cs;
	logic signed [16:0] omc;
	logic signed [32:0] kv6;
	logic signed [31:0] vcs_s7 [3];
	logic signed [48:0] crsn_s7 [3];
	logic signed [49:0] kvomc_s7;
	logic [SIDE_W-1:0]  side_s7;

	assign q6  = side_s6[1:0];
	assign kv6 = side_s6[O_KV +: 33];

	always_comb begin
		case (q6)
			2'd0: begin
				sn = $signed({1'b0, sx_s6}); cs = $signed({1'b0, cx_s6});
			end
			2'd1: begin
				sn = $signed({1'b0, cx_s6}); cs = -$signed({1'b0, sx_s6});
			end
			2'd2: begin
				sn = -$signed({1'b0, sx_s6}); cs = -$signed({1'b0, cx_s6});
			end
			default: begin
				sn = -$signed({1'b0, cx_s6}); cs = $signed({1'b0, sx_s6});
			end
		endcase
		omc = 17'sd16384 - 17'(cs);
	end

	always_ff @(posedge clk) begin
		if (en[1] && vld_q[0]) begin
			for (int i = 0; i < 3; i++) begin
				vcs_s7[i]  <= $signed(side_s6[O_V + 16*i +: 16]) * cs;
				crsn_s7[i] <= $signed(side_s6[O_CR + 33*i +: 33]) * sn;
			end
			kvomc_s7 <= kv6 * omc;
			side_s7  <= side_s6;
		end
	end

	// s8: sum of the three Rodrigues terms, Q56
	logic signed [65:0] kt [3];
	logic signed [63:0] w_s8 [3];
	logic [15:0]        tag_s8;
	logic [CW-1:0]      cen_s8;
	logic [15:0]        rad_s8;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			kt[i] = $signed(side_s7[O_K + 16*i +: 16]) * kvomc_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2] && vld_q[1]) begin
			for (int i = 0; i < 3; i++) begin
				w_s8[i] <= (64'(vcs_s7[i]) <<< 28) + (64'(crsn_s7[i]) <<< 14) + 64'(kt[i]);
			end
			tag_s8 <= side_s7[O_TAG +: 16];
			cen_s8 <= side_s7[O_CEN +: CW];
			rad_s8 <= side_s7[O_RAD +: 16];
		end
	end

	// s9: round to Q20
	logic [63:0]        wr [3];
	logic signed [27:0] rot_s9 [3];
	logic [15:0]        tag_s9, rad_s9;
	logic [CW-1:0]      cen_s9;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wr[i] = w_s8[i] + (64'sd1 <<< 35);
		end
	end

	always_ff @(posedge clk) begin
		if (en[3] && vld_q[2]) begin
			for (int i = 0; i < 3; i++) begin
				rot_s9[i] <= wr[i][63:36];
			end
			tag_s9 <= tag_s8;
			cen_s9 <= cen_s8;
			rad_s9 <= rad_s8;
		end
	end

	// s10: scale by radius, Q28
	logic signed [44:0] off_s10 [3];
	logic [15:0]        tag_s10;
	logic [CW-1:0]      cen_s10;

	always_ff @(posedge clk) begin
		if (en[4] && vld_q[3]) begin
			for (int i = 0; i < 3; i++) begin
				off_s10[i] <= rot_s9[i] * $signed({1'b0, rad_s9});
			end
			tag_s10 <= tag_s9;
			cen_s10 <= cen_s9;
		end
	end

	// s11: round to Q8, add centre, saturate
	logic signed [44:0]      offr [3];
	logic signed [SUM_W-1:0] sum  [3];
	logic [CW-1:0]           vtx_d;
	logic [CW-1:0]           vtx_q;
	logic [15:0]             tag_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			offr[i] = (off_s10[i] + 45'sd524288) >>> 20;
			sum[i]  = SUM_W'($signed(cen_s10[COORD_BITS*i +: COORD_BITS])) + SUM_W'(offr[i]);
			if (sum[i] > MAXV) begin
				vtx_d[COORD_BITS*i +: COORD_BITS] = MAXV[COORD_BITS-1:0];
			end else if (sum[i] < MINV) begin
				vtx_d[COORD_BITS*i +: COORD_BITS] = MINV[COORD_BITS-1:0];
			end else begin
				vtx_d[COORD_BITS*i +: COORD_BITS] = sum[i][COORD_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[5] && vld_q[4]) begin
			vtx_q <= vtx_d;
			tag_q <= tag_s10;
		end
	end

	assign tag    = tag_q;
	assign vertex = vtx_q;

`ifndef SYNTH
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[NSTG-1] && !out_ready |=> vld_q[NSTG-1])
		else $error("result word dropped while stalled");
	a_sine_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[0] |-> (sx_s6 <= SIN_ONE) && (cx_s6 <= SIN_ONE))
		else $error("sine out of range");
	a_omc_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[0] |-> (omc >= 0) && (omc <= 17'sd32768))
		else $error("one minus cosine out of range");
	a_mid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[2] && !en[3] |=> vld_q[2] && $stable(w_s8[0]))
		else $error("stalled stage lost its word");
`endif

endmodule
`default_nettype wire

// ===== hdl/tube_surface_point_core.sv =====
// Tube surface point core: top level with input stage, Horner cell chain and rotate stages.
// Usage:
//  Input channel s_t*: one word per centreline point (tangent, reference axis,
//  centre, angle, radius, index tag). Output channel m_t*: one vertex word per
//  input word, same order, tag copied through.
//  The core is a fixed pipeline of 11 register stages: input stage, four
//  Horner cells of the quarter-sine polynomial, then six rotate/scale stages.
//  m_tvalid rises once the input word has been registered in each of these
//  stages in turn.
//  Throughput is one word per cycle while m_tready stays high; each Horner cell
//  has one multiplier per lane and no stage is reused.
//  Each stage loads when it is empty or its successor loads, so bubbles close
//  up and s_tready stays high while the pipeline has a free slot even when
//  m_tready is low. A full pipeline with m_tready low holds every word.
//  arst_n clears all valid flags; no word is in flight after reset and no
//  clearing pass is needed.
//  Vertex coordinates saturate to the signed COORD_BITS range.
`default_nettype none
module tube_surface_point_core import tsp_pkg::*; #(
	parameter int ANGLE_BITS = 16,
	parameter int COORD_BITS = 24
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output      logic                 s_tready,
	// point_index, tangent_x/y/z, ref_x/y/z, centre_x/y/z, angle, tube_radius
	input  wire logic [((128 + 3*COORD_BITS + ANGLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	output      logic                 m_tvalid,
	input  wire logic                 m_tready,
	// tag_out, vertex_x, vertex_y, vertex_z
	output      logic [((16 + 3*COORD_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

	localparam int OUT_W  = ((16 + 3*COORD_BITS + 7) / 8) * 8;
	localparam int CW     = 3 * COORD_BITS;
	localparam int F_K    = 16;
	localparam int F_V    = 64;
	localparam int F_C    = 112;
	localparam int F_A    = F_C + CW;
	localparam int F_R    = F_A + ANGLE_BITS;
	localparam int SIDE_W = 262 + CW;

	// input stage: phase split, u*u, cross and dot products
	logic [31:0]               phase;
	logic [16:0]               u0, u1;
	logic [33:0]               sq0, sq1;
	logic signed [15:0]        kk [3];
	logic signed [15:0]        vv [3];
	logic signed [32:0]        kv;
	logic signed [32:0]        cr [3];
	sine_lane_t [SINE_LANES-1:0] lane_d, lane_s1;
	logic [SIDE_W-1:0]         side_d, side_s1;
	logic                      valid_s1;
	logic                      ready_s1;

	always_comb begin
		phase = 32'(s_tdata[F_A +: ANGLE_BITS]) << (32 - ANGLE_BITS);
		u0    = {1'b0, phase[29:14]};
		u1    = 17'd65536 - u0;
		sq0   = 34'(u0) * 34'(u0);
		sq1   = 34'(u1) * 34'(u1);
		for (int i = 0; i < 3; i++) begin
			kk[i] = $signed(s_tdata[F_K + 16*i +: 16]);
			vv[i] = $signed(s_tdata[F_V + 16*i +: 16]);
		end
		kv    = 33'(kk[0]) * 33'(vv[0]) + 33'(kk[1]) * 33'(vv[1])
			+ 33'(kk[2]) * 33'(vv[2]);
		cr[0] = 33'(kk[1]) * 33'(vv[2]) - 33'(kk[2]) * 33'(vv[1]);
		cr[1] = 33'(kk[2]) * 33'(vv[0]) - 33'(kk[0]) * 33'(vv[2]);
		cr[2] = 33'(kk[0]) * 33'(vv[1]) - 33'(kk[1]) * 33'(vv[0]);
		lane_d[0].u = u0;
		lane_d[0].z = sq0[32:2];
		lane_d[0].r = SIN_C9;
		lane_d[1].u = u1;
		lane_d[1].z = sq1[32:2];
		lane_d[1].r = SIN_C9;
		side_d = {kv, cr[2], cr[1], cr[0], s_tdata[F_R +: 16], s_tdata[F_C +: CW],
			s_tdata[F_V +: 48], s_tdata[F_K +: 48], s_tdata[15:0], phase[31:30]};
	end

	assign s_tready = !valid_s1 || ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			lane_s1 <= lane_d;
			side_s1 <= side_d;
		end
	end

	// Horner cell chain
	logic                        c_valid [HORNER_CELLS+1];
	logic                        c_ready [HORNER_CELLS+1];
	sine_lane_t [SINE_LANES-1:0] c_lane  [HORNER_CELLS+1];
	logic [SIDE_W-1:0]           c_side  [HORNER_CELLS+1];

	assign c_valid[0] = valid_s1;
	assign ready_s1   = c_ready[0];
	assign c_lane[0]  = lane_s1;
	assign c_side[0]  = side_s1;

	for (genvar g = 0; g < HORNER_CELLS; g++) begin : g_cell
		tsp_sine_cell #(
			.COEF   (horner_coef(g)),
			.SIDE_W (SIDE_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (c_valid[g]),
			.in_ready  (c_ready[g]),
			.in_lane   (c_lane[g]),
			.in_side   (c_side[g]),
			.out_valid (c_valid[g+1]),
			.out_ready (c_ready[g+1]),
			.out_lane  (c_lane[g+1]),
			.out_side  (c_side[g+1])
		);
	end

	logic [15:0] tag;
	logic [CW-1:0] vertex;

	tsp_axis_rotate #(
		.COORD_BITS (COORD_BITS),
		.SIDE_W     (SIDE_W)
	) u_rotate (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (c_valid[HORNER_CELLS]),
		.in_ready  (c_ready[HORNER_CELLS]),
		.in_lane   (c_lane[HORNER_CELLS]),
		.in_side   (c_side[HORNER_CELLS]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.tag       (tag),
		.vertex    (vertex)
	);

	assign m_tdata = OUT_W'({vertex, tag});

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for the tube surface point core: directed and random vertex streams
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import tsp_pkg::*;

	localparam int IN_W  = 216;
	localparam int OUT_W = 88;
	localparam int RANDOM_WORDS = 1850;
	localparam int QUIET_WORDS  = 150;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	bit quiet = 1'b0;

	always #1 clk = ~clk;

	tube_surface_point_core DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	class vertex_scoreboard;
		logic [OUT_W-1:0] pending_vertices[$];
		int mismatches = 0;
		int words_in = 0;
		int words_out = 0;

		task report(string what);
			$display("[%0t] mismatch: %s", $realtime, what);
			mismatches++;
		endtask

		// quarter-wave sine, Q16 position in, Q14 out
		function longint quarter_wave(longint u);
			longint big, z, r, res;
			big = u * 64'sd16384;
			z = (big * big) >>> 30;
			r = 64'sd172272;
			r = -64'sd5026995 + ((r * z) >>> 30);
			r = 64'sd85569306 + ((r * z) >>> 30);
			r = -64'sd693598668 + ((r * z) >>> 30);
			r = 64'sd1686629713 + ((r * z) >>> 30);
			res = (((r * big) >>> 30) + 64'sd32768) >>> 16;
			if (res < 0) res = 0;
			if (res > 16384) res = 16384;
			return res;
		endfunction

		function logic [OUT_W-1:0] surface_vertex(logic [IN_W-1:0] w);
			longint k[3], v[3], c[3], cr[3];
			longint sx, cx, sn, cs, kv, omc, radius, acc, rot, off, s;
			logic [15:0] a;
			logic [OUT_W-1:0] res;
			for (int i = 0; i < 3; i++) begin
				k[i] = longint'($signed(w[16 + 16*i +: 16]));
				v[i] = longint'($signed(w[64 + 16*i +: 16]));
				c[i] = longint'($signed(w[112 + 24*i +: 24]));
			end
			a = w[199:184];
			radius = longint'(w[215:200]);
			sx = quarter_wave(longint'({a[13:0], 2'b00}));
			cx = quarter_wave(64'sd65536 - longint'({a[13:0], 2'b00}));
			case (a[15:14])
				2'd0: begin sn = sx; cs = cx; end
				2'd1: begin sn = cx; cs = -sx; end
				2'd2: begin sn = -sx; cs = -cx; end
				default: begin sn = -cx; cs = sx; end
			endcase
			kv = k[0]*v[0] + k[1]*v[1] + k[2]*v[2];
			omc = 64'sd16384 - cs;
			cr[0] = k[1]*v[2] - k[2]*v[1];
			cr[1] = k[2]*v[0] - k[0]*v[2];
			cr[2] = k[0]*v[1] - k[1]*v[0];
			res[15:0] = w[15:0];
			for (int i = 0; i < 3; i++) begin
				acc = v[i]*cs*(64'sd1 <<< 28) + cr[i]*sn*64'sd16384 + k[i]*kv*omc;
				rot = (acc + (64'sd1 <<< 35)) >>> 36;
				off = (rot * radius + (64'sd1 <<< 19)) >>> 20;
				s = c[i] + off;
				if (s > 64'sd8388607) s = 64'sd8388607;
				if (s < -64'sd8388608) s = -64'sd8388608;
				res[16 + 24*i +: 24] = s[23:0];
			end
			return res;
		endfunction

		function void note_input(logic [IN_W-1:0] w);
			pending_vertices = {pending_vertices, surface_vertex(w)};
			words_in++;
		endfunction

		task check_vertex(logic [OUT_W-1:0] got);
			logic [OUT_W-1:0] exp;
			words_out++;
			if (pending_vertices.size() == 0) begin
				report($sformatf("unexpected vertex %h", got));
				return;
			end
			exp = pending_vertices.pop_front();
			if (got[15:0] !== exp[15:0])
				report($sformatf("tag got %h exp %h", got[15:0], exp[15:0]));
			for (int i = 0; i < 3; i++)
				if (got[16 + 24*i +: 24] !== exp[16 + 24*i +: 24])
					report($sformatf("tag %h axis %0d got %h exp %h", exp[15:0], i,
						got[16 + 24*i +: 24], exp[16 + 24*i +: 24]));
		endtask
	endclass

	vertex_scoreboard sb = new();

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) sb.note_input(s_tdata);
		if (arst_n && m_tvalid && m_tready) sb.check_vertex(m_tdata);
	end

	// output side back-pressure in bursts
	int stall_left = 0;
	int free_left = 0;
	always @(negedge clk) begin
		if (quiet || !arst_n) begin
			m_tready <= arst_n;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (free_left > 0) begin
			free_left--;
			m_tready <= 1'b1;
		end else if ($urandom_range(0, 2) == 0) begin
			stall_left = $urandom_range(1, 8) - 1;
			m_tready <= 1'b0;
		end else begin
			free_left = $urandom_range(0, 30);
			m_tready <= 1'b1;
		end
	end

	function automatic logic [IN_W-1:0] pack_word(logic [15:0] idx, logic [15:0] t[3],
			logic [15:0] r[3], logic [23:0] c[3], logic [15:0] ang, logic [15:0] rad);
		return {rad, ang, c[2], c[1], c[0], r[2], r[1], r[0], t[2], t[1], t[0], idx};
	endfunction

	task send_word(logic [IN_W-1:0] w);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8) - 1) @(negedge clk);
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task drop_valid();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	// random unit tangent and a unit axis perpendicular to it
	task unit_frame(output logic [15:0] t[3], output logic [15:0] r[3]);
		real th, ph, rl, e1[3], e2[3];
		th = 3.14159265 * $urandom_range(0, 10000) / 10000.0;
		ph = 6.28318531 * $urandom_range(0, 10000) / 10000.0;
		rl = 6.28318531 * $urandom_range(0, 10000) / 10000.0;
		e1[0] = $cos(th)*$cos(ph); e1[1] = $cos(th)*$sin(ph); e1[2] = -$sin(th);
		e2[0] = -$sin(ph); e2[1] = $cos(ph); e2[2] = 0.0;
		t[0] = 16'($rtoi($sin(th)*$cos(ph)*16384.0));
		t[1] = 16'($rtoi($sin(th)*$sin(ph)*16384.0));
		t[2] = 16'($rtoi($cos(th)*16384.0));
		for (int i = 0; i < 3; i++)
			r[i] = 16'($rtoi(($cos(rl)*e1[i] + $sin(rl)*e2[i]) * 16384.0));
	endtask

	task random_word(int n);
		logic [15:0] t[3], r[3], ang, rad;
		logic [23:0] c[3];
		int kind;
		kind = $urandom_range(0, 9);
		if (kind < 8) unit_frame(t, r);
		else for (int i = 0; i < 3; i++) begin
			t[i] = 16'($urandom); r[i] = 16'($urandom);
		end
		for (int i = 0; i < 3; i++)
			c[i] = ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(0, 65535) - 32768);
		ang = 16'($urandom);
		rad = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4095));
		send_word(pack_word(16'(n), t, r, c, ang, rad));
	endtask

	task wait_drained();
		while (sb.pending_vertices.size() != 0) @(posedge clk);
	endtask

	initial begin
		logic [15:0] t[3], r[3];
		logic [23:0] c[3];
		logic [15:0] angles[8];
		angles = '{16'h0000, 16'h0001, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF,
			16'h2000, 16'hA555};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// tangent along x, axis along y, every quadrant boundary
		t = '{16'sd16384, 16'sd0, 16'sd0};
		r = '{16'sd0, 16'sd16384, 16'sd0};
		c = '{24'sd0, 24'sd0, 24'sd0};
		foreach (angles[i]) send_word(pack_word(16'(i), t, r, c, angles[i], 16'h0100));
		// tangent along z with radius extremes
		t = '{16'sd0, 16'sd0, 16'sd16384};
		r = '{-16'sd16384, 16'sd0, 16'sd0};
		send_word(pack_word(16'd100, t, r, c, 16'h1234, 16'h0000));
		send_word(pack_word(16'hFFFF, t, r, c, 16'h4000, 16'hFFFF));
		// saturation at both ends of the coordinate range
		c = '{24'h7FFFFF, 24'h800000, 24'h7FFFF0};
		send_word(pack_word(16'd101, t, r, c, 16'h0000, 16'hFFFF));
		send_word(pack_word(16'd102, t, r, c, 16'h8000, 16'hFFFF));
		c = '{24'h800000, 24'h7FFFFF, 24'h800010};
		send_word(pack_word(16'd103, t, r, c, 16'hC000, 16'hFFFF));
		// non-unit and extreme raw vectors
		t = '{16'h8000, 16'h7FFF, 16'h8000};
		r = '{16'h7FFF, 16'h8000, 16'hFFFF};
		send_word(pack_word(16'd104, t, r, c, 16'h5A5A, 16'hFFFF));
		t = '{16'sd16384, 16'sd16384, 16'sd0};
		r = '{16'sd16384, 16'sd0, 16'sd0};
		c = '{24'sd1000, -24'sd1000, 24'sd0};
		send_word(pack_word(16'd105, t, r, c, 16'h3000, 16'h0800));
		t = '{16'sd0, 16'sd0, 16'sd0};
		send_word(pack_word(16'd106, t, r, c, 16'h7777, 16'h0100));
		drop_valid();
		wait_drained();

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == RANDOM_WORDS - QUIET_WORDS) quiet = 1'b1;
			if (n == RANDOM_WORDS / 2) begin
				drop_valid();
				wait_drained();
			end
			random_word(n);
		end
		drop_valid();
		wait_drained();
		repeat (30) @(posedge clk);
		$display("Covered %0d points in, %0d vertices out: quadrant edges, saturation,",
			sb.words_in, sb.words_out);
		$display("raw non-unit vectors and random unit frames under random stalls.");
		if (sb.mismatches == 0 && sb.pending_vertices.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#1000000;
		$display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/tsp_pkg.sv
hdl/tsp_sine_cell.sv
hdl/tsp_axis_rotate.sv
hdl/tube_surface_point_core.sv
dv/tb_top.sv
